>>> src/m128_pkg.sv
// ----------------------------------------------------------------------------
// m128_pkg
// Constants and round functions shared by the Midori128 datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package m128_pkg;

  localparam int NUM_ROUNDS = 19;
  localparam int BLOCK_W    = 128;
  localparam int WORD_W     = 64;
  localparam int APB_ADDR_W = 4;

  localparam logic [3:0] SBOX [16] = '{
    4'h1, 4'h0, 4'h5, 4'h3, 4'he, 4'h2, 4'hf, 4'h7,
    4'hd, 4'ha, 4'h9, 4'hb, 4'hc, 4'h8, 4'h4, 4'h6
  };

  // Per-row bit permutations, position 0 is the MSB: out[p] = in[perm[p]]
  localparam logic [2:0] BIT_FWD [4][8] = '{
    '{3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7},
    '{3'd1, 3'd6, 3'd7, 3'd0, 3'd5, 3'd2, 3'd3, 3'd4},
    '{3'd2, 3'd3, 3'd4, 3'd1, 3'd6, 3'd7, 3'd0, 3'd5},
    '{3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6}
  };
  localparam logic [2:0] BIT_INV [4][8] = '{
    '{3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7},
    '{3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd1, 3'd2},
    '{3'd6, 3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5},
    '{3'd5, 3'd2, 3'd3, 3'd4, 3'd1, 3'd6, 3'd7, 3'd0}
  };

  localparam logic [3:0] SHUF_FWD [16] = '{
    4'd0, 4'd10, 4'd5, 4'd15, 4'd14, 4'd4, 4'd11, 4'd1,
    4'd9, 4'd3, 4'd12, 4'd6, 4'd7, 4'd13, 4'd2, 4'd8
  };
  localparam logic [3:0] SHUF_INV [16] = '{
    4'd0, 4'd7, 4'd14, 4'd9, 4'd5, 4'd2, 4'd11, 4'd12,
    4'd15, 4'd8, 4'd1, 4'd6, 4'd10, 4'd13, 4'd4, 4'd3
  };

  // Round-constant matrices, row-major, first element in the MSB
  localparam logic [15:0] RCONST [NUM_ROUNDS] = '{
    16'h243F, 16'h6A88, 16'h85A3, 16'h08D3, 16'h1319, 16'h8A2E, 16'h0370,
    16'h7344, 16'hA409, 16'h3822, 16'h299F, 16'h31D0, 16'h082E, 16'hFA98,
    16'hEC4E, 16'h6C89, 16'h4528, 16'h21E6, 16'h38D0
  };

  typedef logic [BLOCK_W-1:0] block_t;

  // Byte b of a block sits at bits [(15-b)*8 +: 8]
  function automatic logic [7:0] sub_byte(input logic [7:0] v, input logic [1:0] row);
    logic [7:0] t;
    logic [7:0] u;
    logic [7:0] r;
    for (int p = 0; p < 8; p++) begin
      t[3'(7 - p)] = v[3'd7 - BIT_FWD[row][p]];
    end
    u = {SBOX[t[7:4]], SBOX[t[3:0]]};
    for (int p = 0; p < 8; p++) begin
      r[3'(7 - p)] = u[3'd7 - BIT_INV[row][p]];
    end
    return r;
  endfunction

  function automatic block_t sub_cell(input block_t s);
    block_t r;
    for (int b = 0; b < 16; b++) begin
      r[(15 - b) * 8 +: 8] = sub_byte(s[(15 - b) * 8 +: 8], 2'(b));
    end
    return r;
  endfunction

  function automatic block_t shuffle_fwd(input block_t s);
    block_t r;
    for (int b = 0; b < 16; b++) begin
      r[(15 - b) * 8 +: 8] = s[(15 - int'(SHUF_FWD[b])) * 8 +: 8];
    end
    return r;
  endfunction

  function automatic block_t shuffle_inv(input block_t s);
    block_t r;
    for (int b = 0; b < 16; b++) begin
      r[(15 - b) * 8 +: 8] = s[(15 - int'(SHUF_INV[b])) * 8 +: 8];
    end
    return r;
  endfunction

  // Each byte becomes the XOR of the other three in its column
  function automatic block_t mix_column(input block_t s);
    block_t     r;
    logic [7:0] all;
    for (int c = 0; c < 4; c++) begin
      all = s[(15 - 4 * c) * 8 +: 8] ^ s[(14 - 4 * c) * 8 +: 8] ^
            s[(13 - 4 * c) * 8 +: 8] ^ s[(12 - 4 * c) * 8 +: 8];
      for (int k = 0; k < 4; k++) begin
        r[(15 - 4 * c - k) * 8 +: 8] = s[(15 - 4 * c - k) * 8 +: 8] ^ all;
      end
    end
    return r;
  endfunction

  // Key with round-constant bit folded into each byte's LSB
  function automatic block_t round_key(input block_t key, input int idx);
    block_t r;
    int     m;
    for (int b = 0; b < 16; b++) begin
      m = (b & 3) * 4 + (b >> 2);
      r[(15 - b) * 8 +: 8] = key[(15 - b) * 8 +: 8] ^ {7'd0, RCONST[idx][15 - m]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/m128_round.sv
// ----------------------------------------------------------------------------
// m128_round
// One Midori128 round, forward or equivalent-inverse order.
// ----------------------------------------------------------------------------
`default_nettype none

module m128_round (
  input  wire logic               decrypt,
  input  wire m128_pkg::block_t   enc_key,
  input  wire m128_pkg::block_t   dec_key,
  input  wire m128_pkg::block_t   state_in,
  output m128_pkg::block_t        state_out
);

  m128_pkg::block_t sub;

  always_comb begin
    sub = m128_pkg::sub_cell(state_in);
    if (decrypt) begin
      state_out = m128_pkg::shuffle_inv(m128_pkg::mix_column(sub)) ^ dec_key;
    end else begin
      state_out = m128_pkg::mix_column(m128_pkg::shuffle_fwd(sub)) ^ enc_key;
    end
  end

endmodule

`default_nettype wire

>>> src/m128_datapath.sv
// ----------------------------------------------------------------------------
// m128_datapath
// Unrolled cipher: whitening, 19 rounds, final SubCell and whitening.
// ----------------------------------------------------------------------------
`default_nettype none

module m128_datapath (
  input  wire m128_pkg::block_t   key,
  input  wire logic               decrypt,
  input  wire m128_pkg::block_t   block_in,
  output m128_pkg::block_t        block_out
);

  m128_pkg::block_t chain [m128_pkg::NUM_ROUNDS+1];

  assign chain[0] = block_in ^ key;

  for (genvar r = 0; r < m128_pkg::NUM_ROUNDS; r++) begin : g_round
    m128_pkg::block_t ek;
    m128_pkg::block_t dk;

    // key schedule depends only on the key register
    assign ek = m128_pkg::round_key(key, r);
    assign dk = m128_pkg::shuffle_inv(m128_pkg::mix_column(
                  m128_pkg::round_key(key, m128_pkg::NUM_ROUNDS - 1 - r)));

    m128_round u_round (
      .decrypt   (decrypt),
      .enc_key   (ek),
      .dec_key   (dk),
      .state_in  (chain[r]),
      .state_out (chain[r+1])
    );
  end

  assign block_out = m128_pkg::sub_cell(chain[m128_pkg::NUM_ROUNDS]) ^ key;

endmodule

`default_nettype wire

>>> src/midori128_block_cipher.sv
// ----------------------------------------------------------------------------
// midori128_block_cipher
// Midori128 encrypt/decrypt, one 128-bit block per clock while the output side keeps up.
// ----------------------------------------------------------------------------
// The block encrypts (s_tuser = 0) or decrypts (s_tuser = 1) one 128-bit
// block per transaction under the 128-bit key held in two 64-bit APB
// registers (key_high at 0x0, key_low at 0x8). One transaction is accepted
// every cycle while the output side keeps up. m_tvalid is driven by the result
// register, which takes the block from the input register. The input stalls only when the input and result registers
// both hold a block and m_tready is low. The fully unrolled 19-round datapath
// between the two registers sets the clock period, not the rate.
// Change the key only while no transaction is in flight.
`default_nettype none

module midori128_block_cipher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // APB configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [m128_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [m128_pkg::WORD_W-1:0]       pwdata,
  output logic [m128_pkg::WORD_W-1:0]            prdata,
  output logic                                   pready,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [m128_pkg::BLOCK_W-1:0]      s_tdata,  // block_low, block_high
  input  wire logic                              s_tuser,  // operation
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [m128_pkg::BLOCK_W-1:0]           m_tdata   // result_low, result_high
);

  logic [m128_pkg::WORD_W-1:0] key_high;
  logic [m128_pkg::WORD_W-1:0] key_low;
  logic                        cfg_wr;

  // input register stage
  logic                        in_valid;
  logic                        in_op;
  m128_pkg::block_t            in_block;

  // result register stage
  logic                        out_valid;
  m128_pkg::block_t            result;

  m128_pkg::block_t            result_next;
  logic                        advance;

  // --- APB: register select is paddr[3], low bits ignored ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? key_low : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        key_low <= pwdata;
      end else begin
        key_high <= pwdata;
      end
    end
  end

  // --- pipeline control: stage moves when the result slot is free ---
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= s_tuser;
      // block_high is in the low tdata word; byte 0 goes to the block MSBs
      in_block <= {s_tdata[63:0], s_tdata[127:64]};
    end
    if (advance && in_valid) begin
      result <= result_next;
    end
  end

  m128_datapath u_datapath (
    .key       ({key_high, key_low}),
    .decrypt   (in_op),
    .block_in  (in_block),
    .block_out (result_next)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {result[63:0], result[127:64]};

`ifndef SYNTHESIS
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> out_valid)
    else $error("input stage lost a block");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a full pipeline");

  a_key_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && !paddr[3] |=> key_high == $past(pwdata))
    else $error("key_high write not taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
